### hw/rtl/dsp_pkg.sv
// shared types, constants and code decoder for the subtitle pixel decoder
`default_nettype none
package dsp_pkg;

	localparam int COORD_BITS = 12;
	localparam int POS_BITS   = 16;
	localparam int CFG_BITS   = 12;
	localparam int OUT_BITS   = 12;
	localparam int LEN_BITS   = 9;
	localparam int PAL_BITS   = 8;
	localparam int KIND_BITS  = 2;
	localparam int ACC_BITS   = 24;
	localparam int HELD_BITS  = 5;
	localparam int HDR_BITS   = 32;
	localparam int FLEN_BITS  = 16;
	localparam int SUM_W      = ((POS_BITS > FLEN_BITS) ? POS_BITS : FLEN_BITS) + 1;
	localparam int TDATA_BITS = 48;
	localparam int IDX_BITS   = 2;

	localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
	localparam logic [POS_BITS-1:0]   POS_MAX   = '1;
	localparam logic [OUT_BITS-1:0]   OUT_MAX   = '1;

	localparam logic [KIND_BITS-1:0] KIND_RUN  = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_DROP = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_END  = 2'd2;

	localparam logic [IDX_BITS-1:0] REG_START_X = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_START_Y = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_WIDTH   = 2'd2;

	localparam logic [7:0] TYPE_PIX2 = 8'h10;
	localparam logic [7:0] TYPE_PIX4 = 8'h11;
	localparam logic [7:0] TYPE_PIX8 = 8'h12;
	localparam logic [7:0] TYPE_MAP2 = 8'h20;
	localparam logic [7:0] TYPE_MAP4 = 8'h21;
	localparam logic [7:0] TYPE_MAP16 = 8'h22;
	localparam logic [7:0] TYPE_EOL  = 8'hF0;

	localparam logic [LEN_BITS-1:0] RUN2_LONG  = 9'd29;
	localparam logic [LEN_BITS-1:0] RUN4_LONG  = 9'd25;
	localparam logic [LEN_BITS-1:0] RUN2_MID   = 9'd12;
	localparam logic [LEN_BITS-1:0] RUN4_MID   = 9'd9;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_TOP    = 2'd1,
		PH_BOTTOM = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		M_TYPE = 3'd0,
		M_PIX2 = 3'd1,
		M_PIX4 = 3'd2,
		M_PIX8 = 3'd3,
		M_SKIP = 3'd4
	} mode_t;

	typedef struct packed {
		logic [HELD_BITS-1:0] len;
		logic [LEN_BITS-1:0]  cnt;
		logic [PAL_BITS-1:0]  pal;
		logic                 quit;
	} code_t;

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [OUT_BITS-1:0]  x;
		logic [OUT_BITS-1:0]  y;
		logic [LEN_BITS-1:0]  len;
		logic [PAL_BITS-1:0]  pal;
	} res_t;

	typedef struct packed {
		logic       take_byte;
		logic       bit_step;
		logic       push_pend;
		logic       push_end;
		logic       restart;
		logic [2:0] bit_idx;
	} cmd_t;

	typedef struct packed {
		logic pix_go;
		logic emit_w;
		logic end_w;
		logic pend_v;
		logic can_push;
		logic last_q;
	} sts_t;

	// al holds the code bits left aligned, first bit at the top, unfilled bits zero
	function automatic code_t decode_code(mode_t mode, logic [ACC_BITS-1:0] al);
		code_t c;
		c = '0;
		case (mode)
			M_PIX2: begin
				if (al[23:22] != 2'd0) begin
					c.len = 5'd2; c.cnt = 9'd1; c.pal = 8'(al[23:22]);
				end else if (al[21]) begin
					c.len = 5'd8; c.cnt = 9'd3 + 9'(al[20:18]); c.pal = 8'(al[17:16]);
				end else if (!al[20]) begin
					case (al[19:18])
						2'd0: begin c.len = 5'd6; c.quit = 1'b1; end
						2'd1: begin c.len = 5'd6; c.cnt = 9'd2; end
						2'd2: begin
							c.len = 5'd12; c.cnt = RUN2_MID + 9'(al[17:14]);
							c.pal = 8'(al[13:12]);
						end
						default: begin
							c.len = 5'd16; c.cnt = RUN2_LONG + 9'(al[17:10]);
							c.pal = 8'(al[9:8]);
						end
					endcase
				end else begin
					c.len = 5'd4; c.cnt = 9'd1;
				end
			end
			M_PIX4: begin
				if (al[23:20] != 4'd0) begin
					c.len = 5'd4; c.cnt = 9'd1; c.pal = 8'(al[23:20]);
				end else if (!al[19]) begin
					c.len = 5'd8;
					if (al[18:16] != 3'd0) c.cnt = 9'(al[18:16]) + 9'd2;
					else c.quit = 1'b1;
				end else if (!al[18]) begin
					c.len = 5'd12; c.cnt = 9'd4 + 9'(al[17:16]); c.pal = 8'(al[15:12]);
				end else begin
					case (al[17:16])
						2'd0: begin c.len = 5'd8; c.cnt = 9'd1; end
						2'd1: begin c.len = 5'd8; c.cnt = 9'd2; end
						2'd2: begin
							c.len = 5'd16; c.cnt = RUN4_MID + 9'(al[15:12]);
							c.pal = 8'(al[11:8]);
						end
						default: begin
							c.len = 5'd20; c.cnt = RUN4_LONG + 9'(al[15:8]);
							c.pal = 8'(al[7:4]);
						end
					endcase
				end
			end
			default: begin
				if (al[23:16] != 8'd0) begin
					c.len = 5'd8; c.cnt = 9'd1; c.pal = al[23:16];
				end else if (!al[15]) begin
					c.len = 5'd16; c.cnt = 9'(al[14:8]); c.quit = (al[14:8] == 7'd0);
				end else begin
					c.len = 5'd24; c.cnt = 9'(al[14:8]); c.pal = al[7:0];
				end
			end
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/dsp_ctrl.sv
// sequencer for byte intake, bit-serial code parsing and result delivery
`default_nettype none
module dsp_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire dsp_pkg::sts_t sts,
	output dsp_pkg::cmd_t      cmd
);
	import dsp_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_BIT  = 4'b0010,
		S_FIN  = 4'b0100,
		S_END  = 4'b1000
	} state_t;

	state_t     state_q, state_n;
	logic [2:0] bit_q, bit_n;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_n = state_q;
		bit_n   = bit_q;
		cmd     = '0;
		cmd.bit_idx = bit_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take_byte = 1'b1;
					bit_n   = 3'd7;
					state_n = sts.pix_go ? S_BIT : S_FIN;
				end
			end
			S_BIT: begin
				if (!(sts.emit_w && sts.pend_v && !sts.can_push)) begin
					cmd.bit_step = 1'b1;
					if (sts.end_w || bit_q == 3'd0) state_n = S_FIN;
					else bit_n = bit_q - 3'd1;
				end
			end
			S_FIN: begin
				if (sts.pend_v) begin
					cmd.push_pend = sts.can_push;
				end else begin
					state_n = sts.last_q ? S_END : S_IDLE;
				end
			end
			S_END: begin
				if (sts.can_push) begin
					cmd.push_end = 1'b1;
					cmd.restart  = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bit_q   <= 3'd7;
		end else begin
			state_q <= state_n;
			bit_q   <= bit_n;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/dsp_datapath.sv
// parse state, bit accumulator, coordinates, pending result and output register
`default_nettype none
module dsp_datapath (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [dsp_pkg::IDX_BITS-1:0]     cfg_index,
	input  wire logic [dsp_pkg::CFG_BITS-1:0]     cfg_data,
	input  wire logic [7:0]                       in_byte,
	input  wire logic                             in_last,
	input  wire dsp_pkg::cmd_t                    cmd,
	output dsp_pkg::sts_t                         sts,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output dsp_pkg::res_t                         out_res,
	output logic                                  out_last
);
	import dsp_pkg::*;

	function automatic logic [COORD_BITS-1:0] sat_cfg(logic [SUM_W-1:0] v);
		return (v > SUM_W'(COORD_MAX)) ? COORD_MAX : COORD_BITS'(v);
	endfunction

	function automatic logic [POS_BITS-1:0] sat_pos(logic [SUM_W-1:0] v);
		return (v > SUM_W'(POS_MAX)) ? POS_MAX : POS_BITS'(v);
	endfunction

	function automatic logic [OUT_BITS-1:0] sat_out(logic [COORD_BITS-1:0] v);
		return (SUM_W'(v) > SUM_W'(OUT_MAX)) ? OUT_MAX : OUT_BITS'(v);
	endfunction

	logic [CFG_BITS-1:0]   sx_q, sy_q, ow_q;
	logic [POS_BITS-1:0]   bp_q, fe_q;
	logic [HDR_BITS-1:0]   hdr_q;
	phase_t                phase_q;
	mode_t                 mode_q;
	logic [ACC_BITS-1:0]   acc_q;
	logic [HELD_BITS-1:0]  held_q, skip_q;
	logic [COORD_BITS-1:0] cx_q, cy_q;
	logic [7:0]            byte_q;
	logic                  last_q;
	logic                  pend_v_q, out_v_q, out_last_q;
	res_t                  pend_q, out_q;

	// byte level next values
	logic [POS_BITS-1:0]   b_bp, b_fe;
	logic [HDR_BITS-1:0]   b_hdr;
	phase_t                b_phase;
	mode_t                 b_mode;
	logic [HELD_BITS-1:0]  b_skip;
	logic [COORD_BITS-1:0] b_cx, b_cy;
	logic                  b_clr;

	// bit level signals
	logic [ACC_BITS-1:0]   al;
	logic [HELD_BITS-1:0]  held_n, bit_pos;
	code_t                 code;
	logic                  complete, drop;
	logic [SUM_W-1:0]      x_sum;
	res_t                  new_res;
	logic                  can_push;

	assign can_push = !out_v_q || out_ready;

	always_comb begin
		b_bp    = sat_pos(SUM_W'(bp_q) + SUM_W'(1));
		b_hdr   = hdr_q;
		b_fe    = fe_q;
		b_phase = phase_q;
		b_mode  = mode_q;
		b_skip  = skip_q;
		b_cx    = cx_q;
		b_cy    = cy_q;
		b_clr   = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				b_hdr = {hdr_q[HDR_BITS-9:0], in_byte};
				if (b_bp >= POS_BITS'(4)) begin
					b_phase = PH_TOP;
					b_mode  = M_TYPE;
					b_fe    = sat_pos(SUM_W'(b_bp) + SUM_W'(b_hdr[HDR_BITS-1:FLEN_BITS]));
					b_cx    = sat_cfg(SUM_W'(sx_q));
					b_cy    = sat_cfg(SUM_W'(sy_q));
				end
			end
			PH_TOP, PH_BOTTOM: begin
				if (mode_q == M_TYPE) begin
					if (b_phase == PH_TOP && bp_q >= b_fe) begin
						b_phase = PH_BOTTOM;
						b_fe    = sat_pos(SUM_W'(bp_q) + SUM_W'(hdr_q[FLEN_BITS-1:0]));
						b_cx    = sat_cfg(SUM_W'(sx_q));
						b_cy    = sat_cfg(SUM_W'(sy_q) + SUM_W'(1));
					end
					if (b_phase == PH_BOTTOM && bp_q >= b_fe) b_phase = PH_DONE;
					if (b_phase != PH_DONE) begin
						b_mode = M_TYPE;
						b_clr  = 1'b1;
						case (in_byte)
							TYPE_PIX2:  b_mode = M_PIX2;
							TYPE_PIX4:  b_mode = M_PIX4;
							TYPE_PIX8:  b_mode = M_PIX8;
							TYPE_MAP2:  begin b_mode = M_SKIP; b_skip = 5'd2; end
							TYPE_MAP4:  begin b_mode = M_SKIP; b_skip = 5'd4; end
							TYPE_MAP16: begin b_mode = M_SKIP; b_skip = 5'd16; end
							TYPE_EOL: begin
								b_cx = sat_cfg(SUM_W'(sx_q));
								b_cy = sat_cfg(SUM_W'(b_cy) + SUM_W'(2));
							end
							default: ;
						endcase
					end
				end else if (mode_q == M_SKIP) begin
					if (skip_q != '0) b_skip = skip_q - 5'd1;
					if (b_skip == '0) b_mode = M_TYPE;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		bit_pos  = HELD_BITS'(ACC_BITS - 1) - held_q;
		al       = acc_q;
		al[bit_pos] = byte_q[cmd.bit_idx];
		held_n   = held_q + 5'd1;
		code     = decode_code(mode_q, al);
		complete = (code.len <= held_n);
		x_sum    = SUM_W'(cx_q) + SUM_W'(code.cnt);
		drop     = (mode_q != M_PIX4) && (x_sum > SUM_W'(ow_q));
		new_res.kind = drop ? KIND_DROP : KIND_RUN;
		new_res.x    = sat_out(cx_q);
		new_res.y    = sat_out(cy_q);
		new_res.len  = code.cnt;
		new_res.pal  = code.pal;
	end

	assign sts.pix_go   = (phase_q == PH_TOP || phase_q == PH_BOTTOM) &&
		(mode_q == M_PIX2 || mode_q == M_PIX4 || mode_q == M_PIX8);
	assign sts.emit_w   = complete && (code.cnt != '0);
	assign sts.end_w    = complete && (drop || code.quit);
	assign sts.pend_v   = pend_v_q;
	assign sts.can_push = can_push;
	assign sts.last_q   = last_q;

	assign out_valid = out_v_q;
	assign out_res   = out_q;
	assign out_last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q     <= '0;
			sy_q     <= '0;
			ow_q     <= CFG_BITS'(720);
			bp_q     <= '0;
			fe_q     <= '0;
			hdr_q    <= '0;
			phase_q  <= PH_HEADER;
			mode_q   <= M_TYPE;
			acc_q    <= '0;
			held_q   <= '0;
			skip_q   <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
			last_q   <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_START_X: sx_q <= cfg_data;
					REG_START_Y: sy_q <= cfg_data;
					REG_WIDTH:   ow_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_v_q && out_ready) out_v_q <= 1'b0;

			if (cmd.take_byte) begin
				last_q  <= in_last;
				bp_q    <= b_bp;
				hdr_q   <= b_hdr;
				fe_q    <= b_fe;
				phase_q <= b_phase;
				mode_q  <= b_mode;
				skip_q  <= b_skip;
				cx_q    <= b_cx;
				cy_q    <= b_cy;
				if (b_clr) begin
					acc_q  <= '0;
					held_q <= '0;
				end
			end

			if (cmd.bit_step) begin
				if (complete) begin
					acc_q  <= '0;
					held_q <= '0;
					if (drop || code.quit) begin
						mode_q <= M_TYPE;
					end else if (code.cnt != '0) begin
						cx_q <= sat_cfg(x_sum);
					end
					if (code.cnt != '0) begin
						pend_v_q <= 1'b1;
						if (pend_v_q) begin
							out_v_q    <= 1'b1;
							out_q      <= pend_q;
							out_last_q <= 1'b0;
						end
					end
				end else if (held_n >= HELD_BITS'(ACC_BITS)) begin
					acc_q  <= '0;
					held_q <= '0;
				end else begin
					acc_q  <= al;
					held_q <= held_n;
				end
			end

			if (cmd.push_pend) begin
				pend_v_q   <= 1'b0;
				out_v_q    <= 1'b1;
				out_q      <= pend_q;
				out_last_q <= !last_q;
			end

			if (cmd.push_end) begin
				out_v_q    <= 1'b1;
				out_q      <= '{kind: KIND_END, default: '0};
				out_last_q <= 1'b1;
			end

			if (cmd.restart) begin
				bp_q    <= '0;
				hdr_q   <= '0;
				fe_q    <= '0;
				phase_q <= PH_HEADER;
				mode_q  <= M_TYPE;
				acc_q   <= '0;
				held_q  <= '0;
				skip_q  <= '0;
				cx_q    <= sat_cfg(SUM_W'(sx_q));
				cy_q    <= sat_cfg(SUM_W'(sy_q));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte) byte_q <= in_byte;
		if (cmd.bit_step && sts.emit_w) pend_q <= new_res;
	end

endmodule
`default_nettype wire

### hw/rtl/dvb_subtitle_pixel_decoder_unit.sv
// top level of the dvb subtitle pixel data run decoder
//
// bytes of one object's pixel data enter on the s_ channel, s_tlast on the
// final byte. the first four bytes carry the top and bottom field lengths.
// runs leave on the m_ channel: tuser holds the kind (pixel run, dropped
// overflow run, object end), tlast marks the final result caused by a byte.
// configuration (start_x, start_y, object_width) is written through
// cfg_we / cfg_index / cfg_data while the block is idle; the user must keep
// to this, the block does not enforce it. every byte passes through intake
// and finish, a pixel code string byte also through the code parser, one
// bit per cycle while runs can be handed out; a pending run is handed over
// at finish. the final byte of an object adds the object end result.
// results pass through a held pending run and a single output register;
// while m_tready is low the parser halts at the next run it must hand out
// and s_tready stays low. reset clears the parse state and restores the
// configuration defaults (0, 0, 720); the next byte is a header byte.
`default_nettype none
module dvb_subtitle_pixel_decoder_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [dsp_pkg::IDX_BITS-1:0]    cfg_index,
	input  wire logic [dsp_pkg::CFG_BITS-1:0]    cfg_data,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [7:0]                      s_tdata,  // data_byte
	input  wire logic                            s_tlast,  // last_byte
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [dsp_pkg::TDATA_BITS-1:0]       m_tdata,  // run_x, run_y, run_length, palette_index
	output logic [dsp_pkg::KIND_BITS-1:0]        m_tuser,  // kind
	output logic                                 m_tlast   // last_result
);
	import dsp_pkg::*;

	cmd_t cmd;
	sts_t sts;
	res_t res;

	dsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dsp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res),
		.out_last  (m_tlast)
	);

	assign m_tuser = res.kind;
	assign m_tdata = {(TDATA_BITS - 2*OUT_BITS - LEN_BITS - PAL_BITS)'(0),
		res.pal, res.len, res.y, res.x};

endmodule
`default_nettype wire

### hw/rtl/dsp_checker.sv
// port level checks for the subtitle pixel decoder and their binding
`default_nettype none
module dsp_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic                            s_tlast,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [dsp_pkg::TDATA_BITS-1:0]  m_tdata,
	input wire logic [dsp_pkg::KIND_BITS-1:0]   m_tuser,
	input wire logic                            m_tlast
);
	import dsp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_END |-> m_tlast)
		else $error("object end item without last flag");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_END |-> m_tdata == '0)
		else $error("object end item with nonzero data");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("accepted next item before object end");

endmodule

bind dvb_subtitle_pixel_decoder_unit dsp_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire

### tb/dvb_subtitle_pixel_decoder_unit_checker.sv
// run predictor and result checker for the subtitle pixel decoder
`default_nettype none
module dvb_subtitle_pixel_decoder_unit_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [dsp_pkg::IDX_BITS-1:0] cfg_index,
	input  wire logic [dsp_pkg::CFG_BITS-1:0] cfg_data,
	input  wire logic                         s_tvalid,
	input  wire logic                         s_tready,
	input  wire logic [7:0]                   s_tdata,
	input  wire logic                         s_tlast,
	input  wire logic                         m_tvalid,
	input  wire logic                         m_tready,
	input  wire logic [dsp_pkg::TDATA_BITS-1:0] m_tdata,
	input  wire logic [dsp_pkg::KIND_BITS-1:0]  m_tuser,
	input  wire logic                         m_tlast,
	output int                                errors,
	output int                                runs_pending
);
	import dsp_pkg::*;

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] x;
		logic [11:0] y;
		logic [8:0]  len;
		logic [7:0]  pal;
		logic        lst;
	} run_t;

	run_t run_q[$];

	logic [11:0] org_x, org_y, obj_w;
	int unsigned pos_cnt, hdr, fend, acc, held, skip_left, px, py;
	phase_t      phase;
	mode_t       mode;
	int unsigned rdp;
	bit          rdok;

	assign runs_pending = run_q.size();

	function automatic int unsigned clip(int unsigned v, int unsigned m);
		return v > m ? m : v;
	endfunction

	function automatic int unsigned grab(int unsigned n);
		int unsigned v;
		if (!rdok || rdp + n > held) begin
			rdok = 0;
			return 0;
		end
		v = (acc >> (held - rdp - n)) & ((1 << n) - 1);
		rdp += n;
		return v;
	endfunction

	function automatic bit parse_code(output int unsigned cnt, output int unsigned pal,
			output bit quit);
		int unsigned t, s;
		rdp = 0; rdok = 1; cnt = 0; pal = 0; quit = 0;
		if (mode == M_PIX2) begin
			t = grab(2);
			if (t != 0) begin cnt = 1; pal = t; end
			else if (grab(1) != 0) begin cnt = 3 + grab(3); pal = grab(2); end
			else if (grab(1) == 0) begin
				s = grab(2);
				if (s == 0) quit = 1;
				else if (s == 1) cnt = 2;
				else if (s == 2) begin cnt = 12 + grab(4); pal = grab(2); end
				else begin cnt = 29 + grab(8); pal = grab(2); end
			end else cnt = 1;
		end else if (mode == M_PIX4) begin
			t = grab(4);
			if (t != 0) begin cnt = 1; pal = t; end
			else if (grab(1) == 0) begin
				s = grab(3);
				if (s != 0) cnt = s + 2; else quit = 1;
			end else if (grab(1) == 0) begin cnt = 4 + grab(2); pal = grab(4); end
			else begin
				s = grab(2);
				if (s == 0) cnt = 1;
				else if (s == 1) cnt = 2;
				else if (s == 2) begin cnt = 9 + grab(4); pal = grab(4); end
				else begin cnt = 25 + grab(8); pal = grab(4); end
			end
		end else begin
			t = grab(8);
			if (t != 0) begin cnt = 1; pal = t; end
			else if (grab(1) == 0) begin
				cnt = grab(7);
				if (cnt == 0) quit = 1;
			end else begin cnt = grab(7); pal = grab(8); end
		end
		return rdok;
	endfunction

	task automatic push_run(input logic [1:0] k, input int unsigned len, input int unsigned pal);
		run_t r;
		r.kind = k;
		r.x    = (k == KIND_END) ? 12'd0 : 12'(clip(px, 4095));
		r.y    = (k == KIND_END) ? 12'd0 : 12'(clip(py, 4095));
		r.len  = 9'(len);
		r.pal  = 8'(pal);
		r.lst  = 0;
		run_q.push_back(r);
	endtask

	task automatic restart_object();
		pos_cnt = 0; hdr = 0; fend = 0; phase = PH_HEADER; mode = M_TYPE;
		acc = 0; held = 0; skip_left = 0; px = org_x; py = org_y;
	endtask

	task automatic pixel_bits(input logic [7:0] b);
		int unsigned cnt, pal;
		bit quit;
		for (int i = 7; i >= 0; i--) begin
			acc = ((acc << 1) | b[i]) & 24'hFFFFFF;
			held++;
			if (!parse_code(cnt, pal, quit)) begin
				if (held >= 24) begin acc = 0; held = 0; end
				continue;
			end
			acc = 0; held = 0;
			if (mode != M_PIX4 && px + cnt > obj_w) begin
				if (cnt > 0) push_run(KIND_DROP, cnt, pal);
				mode = M_TYPE;
				break;
			end
			if (quit) begin mode = M_TYPE; break; end
			if (cnt > 0) begin
				push_run(KIND_RUN, cnt, pal);
				px = clip(px + cnt, 4095);
			end
		end
		if (mode == M_TYPE) begin acc = 0; held = 0; end
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic lastb);
		int unsigned p, n0;
		p = pos_cnt;
		n0 = run_q.size();
		pos_cnt = clip(p + 1, 65535);
		if (phase == PH_HEADER) begin
			hdr = (hdr << 8) | b;
			if (pos_cnt >= 4) begin
				phase = PH_TOP; mode = M_TYPE;
				fend = clip(pos_cnt + (hdr >> 16), 65535);
				px = org_x; py = org_y;
			end
		end else if (phase != PH_DONE) begin
			if (mode == M_TYPE) begin
				while (phase != PH_DONE && p >= fend) begin
					if (phase == PH_TOP) begin
						phase = PH_BOTTOM;
						fend = clip(p + (hdr & 16'hFFFF), 65535);
						px = org_x; py = clip(org_y + 1, 4095);
					end else phase = PH_DONE;
				end
				if (phase != PH_DONE) begin
					mode = M_TYPE; acc = 0; held = 0;
					case (b)
						TYPE_PIX2:  mode = M_PIX2;
						TYPE_PIX4:  mode = M_PIX4;
						TYPE_PIX8:  mode = M_PIX8;
						TYPE_MAP2:  begin mode = M_SKIP; skip_left = 2; end
						TYPE_MAP4:  begin mode = M_SKIP; skip_left = 4; end
						TYPE_MAP16: begin mode = M_SKIP; skip_left = 16; end
						TYPE_EOL:   begin px = org_x; py = clip(py + 2, 4095); end
						default: ;
					endcase
				end
			end else if (mode == M_SKIP) begin
				if (skip_left > 0) skip_left--;
				if (skip_left == 0) mode = M_TYPE;
			end else pixel_bits(b);
		end
		if (lastb) begin
			push_run(KIND_END, 0, 0);
			restart_object();
		end
		if (run_q.size() > n0) run_q[$].lst = 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		run_t e;
		if (!arst_n) begin
			org_x = 0; org_y = 0; obj_w = 720;
			restart_object();
			run_q.delete();
			errors = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (run_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected run: kind %0d data %h", m_tuser, m_tdata);
				end else begin
					e = run_q.pop_front();
					if (m_tuser !== e.kind
							|| m_tdata !== TDATA_BITS'({e.pal, e.len, e.y, e.x})
							|| m_tlast !== e.lst) begin
						errors++;
						if (errors <= 10)
							$display("run mismatch: exp k%0d x%0d y%0d n%0d p%0d l%0d, got k%0d x%0d y%0d n%0d p%0d l%0d",
								e.kind, e.x, e.y, e.len, e.pal, e.lst, m_tuser,
								m_tdata[11:0], m_tdata[23:12], m_tdata[32:24],
								m_tdata[40:33], m_tlast);
					end
				end
			end
			if (s_tvalid && s_tready) predict_byte(s_tdata, s_tlast);
			if (cfg_we) begin
				case (cfg_index)
					REG_START_X: org_x = cfg_data;
					REG_START_Y: org_y = cfg_data;
					REG_WIDTH:   obj_w = cfg_data;
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

### tb/dvb_subtitle_pixel_decoder_unit_tb.sv
// stimulus and verdict for the subtitle pixel decoder
`default_nettype none
module dvb_subtitle_pixel_decoder_unit_tb;
	import dsp_pkg::*;

	logic clk, arst_n;
	logic cfg_we;
	logic [IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0] cfg_data;
	logic s_tvalid, s_tready, s_tlast;
	logic [7:0] s_tdata;
	logic m_tvalid, m_tready, m_tlast;
	logic [TDATA_BITS-1:0] m_tdata;
	logic [KIND_BITS-1:0] m_tuser;
	int errors, runs_pending;
	int hold_off;
	int burst_left;
	logic [7:0] obj_q[$];

	dvb_subtitle_pixel_decoder_unit dut (.*);
	dvb_subtitle_pixel_decoder_unit_checker chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("Simulation FAILED");
		$finish;
	end

	// receiver stall pattern, with one long hold-off on request
	initial begin
		m_tready = 0;
		hold_off = 0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_tready <= 0;
				hold_off--;
			end else m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic lst);
		if (burst_left == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		s_tvalid <= 1;
		s_tdata  <= b;
		s_tlast  <= lst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		while (runs_pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [11:0] v);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	// build one object: header plus a top and bottom field of random blocks
	task automatic make_object(input bit noisy);
		logic [7:0] blk[$];
		int top_len, kind_sel, n;
		for (int f = 0; f < 2; f++) begin
			n = $urandom_range(0, 3);
			for (int k = 0; k < n; k++) begin
				kind_sel = $urandom_range(0, 9);
				case (kind_sel)
					0, 1: begin
						blk.push_back(TYPE_PIX2);
						repeat ($urandom_range(1, 4)) blk.push_back(8'($urandom));
						blk.push_back(8'h00);
					end
					2, 3: begin
						blk.push_back(TYPE_PIX4);
						repeat ($urandom_range(1, 4)) blk.push_back(8'($urandom));
						blk.push_back(8'h00); blk.push_back(8'h00);
					end
					4, 5: begin
						blk.push_back(TYPE_PIX8);
						repeat ($urandom_range(1, 5)) blk.push_back(8'($urandom));
						blk.push_back(8'h00); blk.push_back(8'h00);
					end
					6: begin
						blk.push_back(TYPE_MAP2);
						repeat (2) blk.push_back(8'($urandom));
					end
					7: begin
						blk.push_back($urandom_range(0, 1) ? TYPE_MAP4 : TYPE_MAP16);
						repeat (blk[$] == TYPE_MAP4 ? 4 : 16) blk.push_back(8'($urandom));
					end
					8: blk.push_back(TYPE_EOL);
					default: blk.push_back(8'($urandom));
				endcase
			end
			if (f == 0) top_len = blk.size();
		end
		obj_q.delete();
		if (noisy) begin
			obj_q.push_back(8'($urandom)); obj_q.push_back(8'($urandom_range(0, 8)));
			obj_q.push_back(8'($urandom)); obj_q.push_back(8'($urandom_range(0, 8)));
		end else begin
			obj_q.push_back(8'(top_len >> 8)); obj_q.push_back(8'(top_len));
			obj_q.push_back(8'((blk.size() - top_len) >> 8));
			obj_q.push_back(8'(blk.size() - top_len));
		end
		foreach (blk[i]) obj_q.push_back(blk[i]);
		if (noisy && obj_q.size() > 5) obj_q = obj_q[0:$urandom_range(4, obj_q.size() - 1)];
	endtask

	task automatic send_object();
		foreach (obj_q[i]) send_byte(obj_q[i], i == obj_q.size() - 1);
		s_tvalid <= 0;
		@(negedge clk);
	endtask

	task automatic send_list(input logic [7:0] b[$]);
		obj_q = b;
		send_object();
	endtask

	initial begin
		int sent;
		arst_n = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
		s_tvalid = 0; s_tdata = '0; s_tlast = 0;
		burst_left = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: pixel codes of all three depths, map tables, end of line, unknown type
		send_list('{8'h00, 8'h06, 8'h00, 8'h03, TYPE_PIX2, 8'hE4, 8'h2F, 8'h0B,
			8'hFF, 8'hC0, 8'h00, TYPE_EOL, TYPE_MAP2, 8'hAA, 8'h55, 8'h33});
		send_list('{8'h00, 8'h08, 8'h00, 8'h05, TYPE_PIX4, 8'hF1, 8'h0F, 8'h8A,
			8'hCF, 8'hFF, 8'h00, 8'h00, TYPE_MAP4, 8'h01, 8'h02, 8'h03, 8'h04,
			TYPE_PIX8, 8'hFF, 8'h00, 8'h05, 8'h00, 8'hFF, 8'h07, 8'h00, 8'h00});
		drain();
		write_reg(REG_START_X, 12'hFFF);
		write_reg(REG_START_Y, 12'hFFF);
		write_reg(REG_WIDTH, 12'd1);
		// overflow at the extremes, and a short object
		send_list('{8'h00, 8'h03, 8'h00, 8'h00, TYPE_PIX2, 8'h3F, 8'hFF});
		send_list('{8'hFF});
		drain();
		write_reg(REG_START_X, 12'd0);
		write_reg(REG_START_Y, 12'd0);
		write_reg(REG_WIDTH, 12'hFFF);
		send_list('{8'h00, 8'h02, 8'h00, 8'h01, TYPE_PIX8, 8'h00, 8'hFF, 8'hFF,
			TYPE_MAP16, 8'h00, TYPE_EOL});
		// long stall with input kept busy
		hold_off = 300;
		send_list('{8'h00, 8'h05, 8'h00, 8'h00, TYPE_PIX2, 8'hFF, 8'hFF, 8'hFF, 8'h00});
		drain();

		sent = 0;
		while (sent < 190) begin
			if ($urandom_range(0, 7) == 0) begin
				drain();
				write_reg(REG_START_X, 12'($urandom_range(0, 3) == 0 ? 4095 : $urandom_range(0, 600)));
				write_reg(REG_START_Y, 12'($urandom));
				write_reg(REG_WIDTH, 12'($urandom_range(0, 3) == 0 ? $urandom_range(1, 4095)
					: $urandom_range(600, 1000)));
			end
			make_object($urandom_range(0, 9) == 0);
			send_object();
			sent += obj_q.size();
		end
		drain();
		if (errors == 0 && runs_pending == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire

### sim.f
hw/rtl/dsp_pkg.sv
hw/rtl/dsp_ctrl.sv
hw/rtl/dsp_datapath.sv
hw/rtl/dvb_subtitle_pixel_decoder_unit.sv
hw/rtl/dsp_checker.sv
tb/dvb_subtitle_pixel_decoder_unit_checker.sv
tb/dvb_subtitle_pixel_decoder_unit_tb.sv
